FILE: rtl/core/priority_process_selector_unit_assert.svh
// Assertion macros for the checker module pps_chk.
`ifndef PRIORITY_PROCESS_SELECTOR_UNIT_ASSERT_SVH
`define PRIORITY_PROCESS_SELECTOR_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as its trigger.
`define PPS_ASSERT_NOW(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("pps assertion failed");

// Check a consequent in the cycle after its trigger.
`define PPS_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("pps assertion failed");

`endif

FILE: rtl/core/pps_pkg.sv
package pps_pkg;

	localparam int SLOTS_DEF = 64;

	// request codes
	localparam logic [2:0] REQ_LOAD  = 3'd0;
	localparam logic [2:0] REQ_SETP  = 3'd1;
	localparam logic [2:0] REQ_NICE  = 3'd2;
	localparam logic [2:0] REQ_QUERY = 3'd3;
	localparam logic [2:0] REQ_PICK  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOPID = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [1:0] RS_RUNNABLE = 2'd1;

	localparam logic signed [5:0] VAL_PRIO_MIN = 6'sd1;
	localparam logic signed [5:0] VAL_PRIO_MAX = 6'sd10;
	localparam logic signed [5:0] VAL_NICE_MIN = -6'sd20;
	localparam logic signed [5:0] VAL_NICE_MAX = 6'sd19;

	localparam logic [3:0] PRIO_MIN = 4'd1;
	localparam logic [3:0] PRIO_MAX = 4'd10;
	localparam logic [3:0] PRIO_DEF = 4'd5;

	typedef struct packed {
		logic [15:0] pid;
		logic [1:0]  st;
		logic [3:0]  base;
		logic [3:0]  dyn;
		logic [5:0]  nice;
	} ent_t;

	localparam ent_t ENT_RST = '{pid: 16'd0, st: 2'd0, base: PRIO_DEF, dyn: PRIO_DEF,
		nice: 6'd0};

	typedef logic [3:0] upc_t;

	// microprogram step addresses
	localparam upc_t U_IDLE     = 4'd0;
	localparam upc_t U_DECODE   = 4'd1;
	localparam upc_t U_LD_ADDR  = 4'd2;
	localparam upc_t U_LD_WAIT  = 4'd3;
	localparam upc_t U_LD_LATCH = 4'd4;
	localparam upc_t U_SC_FIRST = 4'd5;
	localparam upc_t U_SC_LOOP  = 4'd6;
	localparam upc_t U_NOTF     = 4'd7;
	localparam upc_t U_ERR      = 4'd8;
	localparam upc_t U_MOD      = 4'd9;
	localparam upc_t U_PK_FIRST = 4'd10;
	localparam upc_t U_PK_LOOP  = 4'd11;
	localparam upc_t U_PK_END   = 4'd12;
	localparam upc_t U_EMIT     = 4'd13;
	localparam upc_t U_CLR      = 4'd14;

	// counter operations
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_ZERO = 2'd1;
	localparam logic [1:0] CNT_SLOT = 2'd2;
	localparam logic [1:0] CNT_INC  = 2'd3;

	// entry latch operations
	localparam logic [2:0] LAT_NONE  = 3'd0;
	localparam logic [2:0] LAT_HIT   = 3'd1;
	localparam logic [2:0] LAT_MATCH = 3'd2;
	localparam logic [2:0] LAT_BEST  = 3'd3;
	localparam logic [2:0] LAT_MOD   = 3'd4;
	localparam logic [2:0] LAT_CLRB  = 3'd5;

	// memory write operations
	localparam logic [1:0] WR_NONE = 2'd0;
	localparam logic [1:0] WR_CLR  = 2'd1;
	localparam logic [1:0] WR_MOD  = 2'd2;

	// status operations
	localparam logic [2:0] SO_KEEP  = 3'd0;
	localparam logic [2:0] SO_OK    = 3'd1;
	localparam logic [2:0] SO_RANGE = 3'd2;
	localparam logic [2:0] SO_NOPID = 3'd3;
	localparam logic [2:0] SO_PICK  = 3'd4;

	// jump conditions
	localparam logic [2:0] J_NEXT     = 3'd0;
	localparam logic [2:0] J_GOTO     = 3'd1;
	localparam logic [2:0] J_ACCEPT   = 3'd2;
	localparam logic [2:0] J_DISPATCH = 3'd3;
	localparam logic [2:0] J_SCAN     = 3'd4;
	localparam logic [2:0] J_RLAST    = 3'd5;
	localparam logic [2:0] J_CLAST    = 3'd6;
	localparam logic [2:0] J_OUTFREE  = 3'd7;

	typedef struct packed {
		logic [1:0] cnt_op;
		logic [2:0] lat_op;
		logic [1:0] wr_op;
		logic [2:0] stat_op;
		logic [2:0] jmp;
		upc_t       target;
		logic       in_rdy;
		logic       out_ld;
	} ucode_t;

	typedef struct packed {
		logic accept;
		upc_t disp;
		logic match;
		logic rlast;
		logic clast;
		logic outfree;
	} cond_t;

	function automatic ucode_t uw(input logic [1:0] cnt, input logic [2:0] lat,
		input logic [1:0] wr, input logic [2:0] so, input logic [2:0] jmp,
		input upc_t tgt, input logic rdy, input logic ld);
		ucode_t w;
		w = '{cnt_op: cnt, lat_op: lat, wr_op: wr, stat_op: so, jmp: jmp,
			target: tgt, in_rdy: rdy, out_ld: ld};
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode_rom(input upc_t a);
		ucode_t w;
		unique case (a)
			U_IDLE:     w = uw(CNT_HOLD, LAT_NONE,  WR_NONE, SO_KEEP,  J_ACCEPT,   U_DECODE,
				1'b1, 1'b0);
			U_DECODE:   w = uw(CNT_ZERO, LAT_NONE,  WR_NONE, SO_KEEP,  J_DISPATCH, U_IDLE,
				1'b0, 1'b0);
			U_LD_ADDR:  w = uw(CNT_SLOT, LAT_NONE,  WR_NONE, SO_KEEP,  J_NEXT,     U_IDLE,
				1'b0, 1'b0);
			U_LD_WAIT:  w = uw(CNT_HOLD, LAT_NONE,  WR_NONE, SO_KEEP,  J_NEXT,     U_IDLE,
				1'b0, 1'b0);
			U_LD_LATCH: w = uw(CNT_HOLD, LAT_HIT,   WR_NONE, SO_KEEP,  J_GOTO,     U_MOD,
				1'b0, 1'b0);
			U_SC_FIRST: w = uw(CNT_INC,  LAT_NONE,  WR_NONE, SO_KEEP,  J_NEXT,     U_IDLE,
				1'b0, 1'b0);
			U_SC_LOOP:  w = uw(CNT_INC,  LAT_MATCH, WR_NONE, SO_KEEP,  J_SCAN,     U_MOD,
				1'b0, 1'b0);
			U_NOTF:     w = uw(CNT_HOLD, LAT_NONE,  WR_NONE, SO_NOPID, J_GOTO,     U_EMIT,
				1'b0, 1'b0);
			U_ERR:      w = uw(CNT_HOLD, LAT_NONE,  WR_NONE, SO_RANGE, J_GOTO,     U_EMIT,
				1'b0, 1'b0);
			U_MOD:      w = uw(CNT_HOLD, LAT_MOD,   WR_MOD,  SO_OK,    J_GOTO,     U_EMIT,
				1'b0, 1'b0);
			U_PK_FIRST: w = uw(CNT_INC,  LAT_CLRB,  WR_NONE, SO_KEEP,  J_NEXT,     U_IDLE,
				1'b0, 1'b0);
			U_PK_LOOP:  w = uw(CNT_INC,  LAT_BEST,  WR_NONE, SO_KEEP,  J_RLAST,    U_PK_END,
				1'b0, 1'b0);
			U_PK_END:   w = uw(CNT_HOLD, LAT_NONE,  WR_NONE, SO_PICK,  J_GOTO,     U_EMIT,
				1'b0, 1'b0);
			U_EMIT:     w = uw(CNT_HOLD, LAT_NONE,  WR_NONE, SO_KEEP,  J_OUTFREE,  U_IDLE,
				1'b0, 1'b1);
			U_CLR:      w = uw(CNT_INC,  LAT_NONE,  WR_CLR,  SO_KEEP,  J_CLAST,    U_IDLE,
				1'b0, 1'b0);
			default:    w = uw(CNT_HOLD, LAT_NONE,  WR_NONE, SO_KEEP,  J_GOTO,     U_IDLE,
				1'b0, 1'b0);
		endcase
		return w;
	endfunction

	// base priority from a nice value: 5 + nice/4 toward zero, clamped to 1..10
	function automatic logic [3:0] nice_base(input logic signed [5:0] v);
		logic [5:0] mag;
		logic [3:0] q;
		logic [3:0] np;
		mag = v[5] ? 6'(-v) : 6'(v);
		q   = 4'(mag >> 2);
		np  = v[5] ? PRIO_DEF - q : PRIO_DEF + q;
		if (np < PRIO_MIN) np = PRIO_MIN;
		if (np > PRIO_MAX) np = PRIO_MAX;
		return np;
	endfunction

endpackage

FILE: rtl/core/pps_ram.sv
module pps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/pps_useq.sv
module pps_useq import pps_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cond_t  cond,
	output ucode_t uc
);

	upc_t upc_q;
	upc_t upc_nx;

	assign uc = ucode_rom(upc_q);

	always_comb begin
		unique case (uc.jmp)
			J_NEXT:     upc_nx = upc_t'(upc_q + 4'd1);
			J_GOTO:     upc_nx = uc.target;
			J_ACCEPT:   upc_nx = cond.accept ? uc.target : upc_q;
			J_DISPATCH: upc_nx = cond.disp;
			// match ends the scan; running off the table falls to the next step
			J_SCAN:     upc_nx = cond.match ? uc.target :
				(cond.rlast ? upc_t'(upc_q + 4'd1) : upc_q);
			J_RLAST:    upc_nx = cond.rlast ? uc.target : upc_q;
			J_CLAST:    upc_nx = cond.clast ? uc.target : upc_q;
			J_OUTFREE:  upc_nx = cond.outfree ? uc.target : upc_q;
			default:    upc_nx = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_CLR;
		end else begin
			upc_q <= upc_nx;
		end
	end

endmodule

FILE: rtl/core/pps_dpath.sv
module pps_dpath import pps_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ucode_t             uc,
	output cond_t              cond,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [5:0]         slot,
	input  logic [15:0]        pid,
	input  logic [1:0]         run_state,
	input  logic signed [5:0]  value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [5:0]         found_slot,
	output logic [15:0]        found_pid,
	output logic [3:0]         base_priority,
	output logic [3:0]         dyn_priority
);

	localparam int SW = $clog2(SLOTS);
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

	logic [2:0]        req_q;
	logic [5:0]        slot_q;
	logic [15:0]       pid_q;
	logic [1:0]        rs_q;
	logic signed [5:0] val_q;

	logic [SW-1:0] cnt_q;
	logic [SW-1:0] ridx_s1;
	logic [SW-1:0] hidx_q;
	ent_t          ent_q;
	ent_t          rdata;
	ent_t          ent_mod;
	logic          bestv_q;
	logic [1:0]    stat_q;
	logic          out_valid_q;

	logic          accept;
	logic          take_best;
	logic          hit_ld;
	logic          we;
	logic [SW-1:0] waddr;
	ent_t          wdata;
	upc_t          disp;

	assign accept   = in_valid && uc.in_rdy;
	assign in_ready = uc.in_rdy;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			slot_q <= slot;
			pid_q  <= pid;
			rs_q   <= run_state;
			val_q  <= value;
		end
	end

	// request decode
	always_comb begin
		unique case (req_q)
			REQ_LOAD:  disp = (32'(slot_q) < 32'(SLOTS)) ? U_LD_ADDR : U_ERR;
			REQ_SETP:  disp = (val_q >= VAL_PRIO_MIN && val_q <= VAL_PRIO_MAX) ?
				U_SC_FIRST : U_ERR;
			REQ_NICE:  disp = (val_q >= VAL_NICE_MIN && val_q <= VAL_NICE_MAX) ?
				U_SC_FIRST : U_ERR;
			REQ_QUERY: disp = U_SC_FIRST;
			REQ_PICK:  disp = U_PK_FIRST;
			default:   disp = U_ERR;
		endcase
	end

	assign cond.disp    = disp;
	assign cond.accept  = accept;
	assign cond.match   = (rdata.pid == pid_q);
	assign cond.rlast   = (ridx_s1 == LAST);
	assign cond.clast   = (cnt_q == LAST);
	assign cond.outfree = !out_valid_q || out_ready;

	// apply the request to the latched entry
	always_comb begin
		ent_mod = ent_q;
		case (req_q)
			REQ_LOAD: begin
				ent_mod.pid = pid_q;
				ent_mod.st  = rs_q;
			end
			REQ_SETP: begin
				ent_mod.base = 4'(val_q);
				ent_mod.dyn  = 4'(val_q);
			end
			REQ_NICE: begin
				ent_mod.nice = 6'(val_q);
				ent_mod.base = nice_base(val_q);
			end
			default: ;
		endcase
	end

	assign we    = (uc.wr_op != WR_NONE);
	assign waddr = (uc.wr_op == WR_CLR) ? cnt_q : hidx_q;
	assign wdata = (uc.wr_op == WR_CLR) ? ENT_RST : ent_mod;

	pps_ram #(
		.WIDTH($bits(ent_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(cnt_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (uc.cnt_op)
				CNT_ZERO: cnt_q <= '0;
				CNT_SLOT: cnt_q <= SW'(slot_q);
				CNT_INC:  cnt_q <= SW'(cnt_q + 1'b1);
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	// tag of the entry coming out of the memory this cycle
	always_ff @(posedge clk) begin
		ridx_s1 <= cnt_q;
	end

	assign take_best = (rdata.st == RS_RUNNABLE) && (!bestv_q || rdata.dyn > ent_q.dyn);
	assign hit_ld = (uc.lat_op == LAT_HIT) || (uc.lat_op == LAT_MATCH && cond.match) ||
		(uc.lat_op == LAT_BEST && take_best);

	always_ff @(posedge clk) begin
		if (hit_ld) begin
			ent_q  <= rdata;
			hidx_q <= ridx_s1;
		end else if (uc.lat_op == LAT_MOD) begin
			ent_q <= ent_mod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bestv_q <= 1'b0;
			stat_q  <= ST_OK;
		end else begin
			if (uc.lat_op == LAT_CLRB) begin
				bestv_q <= 1'b0;
			end else if (uc.lat_op == LAT_BEST && take_best) begin
				bestv_q <= 1'b1;
			end
			case (uc.stat_op)
				SO_OK:    stat_q <= ST_OK;
				SO_RANGE: stat_q <= ST_RANGE;
				SO_NOPID: stat_q <= ST_NOPID;
				SO_PICK:  stat_q <= bestv_q ? ST_OK : ST_EMPTY;
				default:  stat_q <= stat_q;
			endcase
		end
	end

	// output register; clear the payload fields on any failing status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uc.out_ld && cond.outfree) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.out_ld && cond.outfree) begin
			status <= stat_q;
			if (stat_q == ST_OK) begin
				found_slot    <= 6'(hidx_q);
				found_pid     <= ent_q.pid;
				base_priority <= ent_q.base;
				dyn_priority  <= ent_q.dyn;
			end else begin
				found_slot    <= '0;
				found_pid     <= '0;
				base_priority <= '0;
				dyn_priority  <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/priority_process_selector_unit.sv
// Process slot table with load, priority set, nice, query and pick requests.
// Input channel: in_valid/in_ready with req_type, slot, pid, run_state, value.
// Output channel: out_valid/out_ready with status, found_slot, found_pid,
// base_priority, dyn_priority; one result item per request item.
// A small microprogram steps a slot memory (one write, one registered read port).
// A load reads the addressed slot and writes it back changed; set, nice and query
// scan from slot 0 and stop at the first pid match; pick scans every slot; a
// rejected request goes straight to its result. The walk over the memory read
// port is serial; one item is in work at a time, so the next item is accepted
// only once the previous result has been loaded into the output register.
// After reset a clearing pass writes every slot to its reset value; in_ready
// stays low until it ends.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its result is held back until out_ready takes the earlier one.
module priority_process_selector_unit import pps_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [5:0]         slot,
	input  logic [15:0]        pid,
	input  logic [1:0]         run_state,
	input  logic signed [5:0]  value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [5:0]         found_slot,
	output logic [15:0]        found_pid,
	output logic [3:0]         base_priority,
	output logic [3:0]         dyn_priority
);

	ucode_t uc;
	cond_t  cond;

	pps_useq u_useq (
		.clk   (clk),
		.arst_n(arst_n),
		.cond  (cond),
		.uc    (uc)
	);

	pps_dpath #(
		.SLOTS(SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.uc           (uc),
		.cond         (cond),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.slot         (slot),
		.pid          (pid),
		.run_state    (run_state),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_slot   (found_slot),
		.found_pid    (found_pid),
		.base_priority(base_priority),
		.dyn_priority (dyn_priority)
	);

endmodule

FILE: rtl/core/pps_chk.sv
`include "priority_process_selector_unit_assert.svh"

module pps_chk import pps_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [2:0]        req_type,
	input logic [5:0]        slot,
	input logic [15:0]       pid,
	input logic [1:0]        run_state,
	input logic signed [5:0] value,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [5:0]        found_slot,
	input logic [15:0]       found_pid,
	input logic [3:0]        base_priority,
	input logic [3:0]        dyn_priority
);

	logic [32:0] in_pay;
	logic [31:0] out_pay;
	logic        fields_zero;
	logic        prio_in_range;

	assign in_pay  = {req_type, slot, pid, run_state, value};
	assign out_pay = {status, found_slot, found_pid, base_priority, dyn_priority};
	assign fields_zero = found_slot == 6'd0 && found_pid == 16'd0 &&
		base_priority == 4'd0 && dyn_priority == 4'd0;
	assign prio_in_range = dyn_priority >= PRIO_MIN && dyn_priority <= PRIO_MAX &&
		base_priority >= PRIO_MIN && base_priority <= PRIO_MAX;

	// one item in work at a time: ready drops right after an accept
	`PPS_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready)

	`PPS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_pay))

	`PPS_ASSERT_NOW(a_fail_zero, out_valid && status != ST_OK, fields_zero)

	`PPS_ASSERT_NOW(a_ok_prio, out_valid && status == ST_OK, prio_in_range)

	`PPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pay))

endmodule

bind priority_process_selector_unit pps_chk u_pps_chk (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import pps_pkg::*; ();

	localparam int SLOTS      = SLOTS_DEF;
	localparam int NICE_STEP  = 4;
	localparam int MAX_REPORT = 40;

	// request codes the block does not define
	localparam logic [2:0] REQ_RSVD5 = 3'd5;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	localparam logic [1:0] RS_UNUSED  = 2'd0;
	localparam logic [1:0] RS_RUNNING = 2'd2;
	localparam logic [1:0] RS_OTHER   = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [15:0] pid;
		logic [3:0]  base;
		logic [3:0]  dyn;
	} sched_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        req_type;
	logic [5:0]        slot;
	logic [15:0]       pid;
	logic [1:0]        run_state;
	logic signed [5:0] value;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        status;
	logic [5:0]        found_slot;
	logic [15:0]       found_pid;
	logic [3:0]        base_priority;
	logic [3:0]        dyn_priority;

	// shadow copy of the slot table
	logic [15:0]       tbl_pid  [SLOTS];
	logic [1:0]        tbl_state[SLOTS];
	logic [3:0]        tbl_base [SLOTS];
	logic [3:0]        tbl_dyn  [SLOTS];
	logic signed [5:0] tbl_nice [SLOTS];

	sched_result_t sched_exp_q[$];
	int            err_count = 0;
	bit            quiet_tx = 1'b0;
	bit            quiet_rx = 1'b0;
	int            rx_hold_left = 0;
	logic [15:0]   pid_pool[8];

	priority_process_selector_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.slot         (slot),
		.pid          (pid),
		.run_state    (run_state),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_slot   (found_slot),
		.found_pid    (found_pid),
		.base_priority(base_priority),
		.dyn_priority (dyn_priority)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic table_reset();
		for (int i = 0; i < SLOTS; i++) begin
			tbl_pid[i]   = '0;
			tbl_state[i] = RS_UNUSED;
			tbl_base[i]  = PRIO_DEF;
			tbl_dyn[i]   = PRIO_DEF;
			tbl_nice[i]  = '0;
		end
	endtask

	function automatic int lookup_pid(input logic [15:0] p);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_pid[i] == p)
				return i;
		return -1;
	endfunction

	// advance the shadow table by one request and return its answer
	function automatic sched_result_t schedule_request(input logic [2:0] req,
		input logic [5:0] sl, input logic [15:0] p, input logic [1:0] rs,
		input logic signed [5:0] v);
		sched_result_t r;
		int idx;
		int best_prio;
		int np;
		r = '0;
		idx = -1;
		case (req)
			REQ_LOAD: begin
				if (int'(sl) >= SLOTS) begin
					r.status = ST_RANGE;
				end else begin
					tbl_pid[sl]   = p;
					tbl_state[sl] = rs;
					idx = int'(sl);
					r.status = ST_OK;
				end
			end
			REQ_SETP: begin
				if (v < VAL_PRIO_MIN || v > VAL_PRIO_MAX) begin
					r.status = ST_RANGE;
				end else begin
					idx = lookup_pid(p);
					if (idx < 0) begin
						r.status = ST_NOPID;
					end else begin
						tbl_base[idx] = 4'(v);
						tbl_dyn[idx]  = 4'(v);
						r.status = ST_OK;
					end
				end
			end
			REQ_NICE: begin
				if (v < VAL_NICE_MIN || v > VAL_NICE_MAX) begin
					r.status = ST_RANGE;
				end else begin
					idx = lookup_pid(p);
					if (idx < 0) begin
						r.status = ST_NOPID;
					end else begin
						// integer division truncates toward zero
						np = int'(PRIO_DEF) + int'(v) / NICE_STEP;
						if (np < int'(PRIO_MIN)) np = int'(PRIO_MIN);
						if (np > int'(PRIO_MAX)) np = int'(PRIO_MAX);
						tbl_nice[idx] = v;
						tbl_base[idx] = 4'(np);
						r.status = ST_OK;
					end
				end
			end
			REQ_QUERY: begin
				idx = lookup_pid(p);
				r.status = (idx < 0) ? ST_NOPID : ST_OK;
			end
			REQ_PICK: begin
				best_prio = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_state[i] == RS_RUNNABLE && int'(tbl_dyn[i]) > best_prio) begin
						best_prio = int'(tbl_dyn[i]);
						idx = i;
					end
				end
				r.status = (idx < 0) ? ST_EMPTY : ST_OK;
			end
			default: r.status = ST_RANGE;
		endcase
		if (r.status == ST_OK) begin
			r.slot = 6'(idx);
			r.pid  = tbl_pid[idx];
			r.base = tbl_base[idx];
			r.dyn  = tbl_dyn[idx];
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 60);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_count < MAX_REPORT)
			$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	task automatic send_request(input logic [2:0] req, input logic [5:0] sl,
		input logic [15:0] p, input logic [1:0] rs, input logic signed [5:0] v);
		int gap;
		gap = quiet_tx ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type  = req;
		slot      = sl;
		pid       = p;
		run_state = rs;
		value     = v;
		in_valid  = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// predict on every accepted item, check on every accepted result
	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (sched_exp_q.size() == 0) begin
				report_mismatch("result with nothing pending, status", status, 0);
			end else begin
				e = sched_exp_q.pop_front();
				if (status !== e.status)
					report_mismatch("status", status, e.status);
				if (found_slot !== e.slot)
					report_mismatch("found_slot", found_slot, e.slot);
				if (found_pid !== e.pid)
					report_mismatch("found_pid", found_pid, e.pid);
				if (base_priority !== e.base)
					report_mismatch("base_priority", base_priority, e.base);
				if (dyn_priority !== e.dyn)
					report_mismatch("dyn_priority", dyn_priority, e.dyn);
			end
		end
		if (arst_n && in_valid && in_ready)
			sched_exp_q.push_back(schedule_request(req_type, slot, pid, run_state, value));
	end

	// result side: random stalls, plus a long hold when asked
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				out_ready = 1'b0;
				rx_hold_left--;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if (!quiet_rx && $urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	task automatic test_reset_state();
		send_request(REQ_QUERY, 6'd0, 16'd0, RS_UNUSED, 6'sd0);
		send_request(REQ_PICK, 6'd0, 16'd0, RS_UNUSED, 6'sd0);
	endtask

	task automatic test_load();
		send_request(REQ_LOAD, 6'd0, 16'hFFFF, RS_RUNNABLE, 6'sd0);
		send_request(REQ_LOAD, 6'd63, 16'h1234, RS_RUNNING, -6'sd1);
		send_request(REQ_LOAD, 6'd5, 16'h0000, RS_OTHER, 6'sd31);
	endtask

	task automatic test_set_priority();
		send_request(REQ_SETP, 6'd0, 16'hFFFF, RS_UNUSED, VAL_PRIO_MAX);
		send_request(REQ_SETP, 6'd0, 16'h1234, RS_UNUSED, VAL_PRIO_MIN);
		send_request(REQ_SETP, 6'd0, 16'hFFFF, RS_UNUSED, 6'sd0);
		send_request(REQ_SETP, 6'd0, 16'hFFFF, RS_UNUSED, 6'sd11);
		send_request(REQ_SETP, 6'd0, 16'hFFFF, RS_UNUSED, -6'sd32);
		send_request(REQ_SETP, 6'd0, 16'hFFFF, RS_UNUSED, 6'sd31);
		send_request(REQ_SETP, 6'd0, 16'hABCD, RS_UNUSED, 6'sd3);
	endtask

	task automatic test_set_nice();
		send_request(REQ_NICE, 6'd0, 16'hFFFF, RS_UNUSED, VAL_NICE_MIN);
		send_request(REQ_NICE, 6'd0, 16'h1234, RS_UNUSED, VAL_NICE_MAX);
		send_request(REQ_NICE, 6'd0, 16'h0000, RS_UNUSED, -6'sd3);
		send_request(REQ_NICE, 6'd0, 16'hFFFF, RS_UNUSED, -6'sd21);
		send_request(REQ_NICE, 6'd0, 16'hFFFF, RS_UNUSED, 6'sd20);
		send_request(REQ_NICE, 6'd0, 16'hBEEF, RS_UNUSED, 6'sd4);
	endtask

	task automatic test_pick_and_unknown();
		send_request(REQ_SETP, 6'd0, 16'hFFFF, RS_UNUSED, VAL_PRIO_MIN);
		send_request(REQ_LOAD, 6'd1, 16'd100, RS_RUNNABLE, 6'sd0);
		send_request(REQ_LOAD, 6'd2, 16'd101, RS_RUNNABLE, 6'sd0);
		// equal priorities on slots one and two: lower index wins
		send_request(REQ_PICK, 6'd0, 16'd0, RS_UNUSED, 6'sd0);
		send_request(REQ_QUERY, 6'd0, 16'h7777, RS_UNUSED, 6'sd0);
		send_request(REQ_RSVD5, 6'd0, 16'hFFFF, RS_UNUSED, 6'sd5);
		send_request(REQ_RSVD7, 6'd63, 16'hFFFF, RS_OTHER, 6'sd5);
	endtask

	task automatic test_output_backpressure();
		quiet_tx = 1'b1;
		rx_hold_left = 500;
		for (int i = 0; i < 12; i++)
			send_request((i % 2 == 0) ? REQ_PICK : REQ_QUERY, 6'($urandom_range(0, 63)),
				16'd100, RS_UNUSED, 6'sd0);
		quiet_tx = 1'b0;
	endtask

	task automatic test_random(input int count);
		int r;
		logic [2:0]        rq;
		logic [5:0]        sl;
		logic [15:0]       p;
		logic [1:0]        rs;
		logic signed [5:0] v;
		for (int i = 0; i < 8; i++)
			pid_pool[i] = 16'($urandom);
		for (int n = 0; n < count; n++) begin
			// stretches with no idling on either side
			quiet_tx = (n % 100) >= 70;
			quiet_rx = (n % 100) >= 70;
			sl = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
			p  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pid_pool[$urandom_range(0, 7)];
			rs = ($urandom_range(0, 1) == 0) ? RS_RUNNABLE : 2'($urandom);
			v  = 6'($urandom);
			r  = $urandom_range(0, 99);
			if (r < 25) begin
				rq = REQ_LOAD;
			end else if (r < 45) begin
				rq = REQ_SETP;
				if ($urandom_range(0, 4) != 0)
					v = 6'($urandom_range(1, 10));
			end else if (r < 65) begin
				rq = REQ_NICE;
				if ($urandom_range(0, 4) != 0)
					v = 6'($urandom_range(0, 39)) - 6'd20;
			end else if (r < 80) begin
				rq = REQ_QUERY;
			end else if (r < 95) begin
				rq = REQ_PICK;
			end else begin
				rq = 3'($urandom_range(int'(REQ_RSVD5), int'(REQ_RSVD7)));
			end
			send_request(rq, sl, p, rs, v);
		end
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
	endtask

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = REQ_LOAD;
		slot      = '0;
		pid       = '0;
		run_state = RS_UNUSED;
		value     = '0;
		table_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_load();
		test_set_priority();
		test_set_nice();
		test_pick_and_unknown();
		test_output_backpressure();
		test_random(500);

		@(negedge clk);
		in_valid = 1'b0;
		while (sched_exp_q.size() != 0) @(posedge clk);
		repeat (SLOTS + 20) @(posedge clk);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: priority_process_selector_unit.f
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/pps_useq.sv
rtl/core/pps_dpath.sv
rtl/core/priority_process_selector_unit.sv
rtl/core/pps_chk.sv
tb/sv/tb.sv
